FILE: src/dllce_pkg.sv
// Package for the doubly linked list cursor engine.
// Holds the command and response types, command and status codes, and the
// sequencer state type. It depends on nothing else.
package dllce_pkg;

  // Command codes carried in the kind field. Codes 11 to 15 are not used.
  localparam logic [3:0] KIND_FIRST      = 4'd0;
  localparam logic [3:0] KIND_NEXT       = 4'd1;
  localparam logic [3:0] KIND_LAST       = 4'd2;
  localparam logic [3:0] KIND_PREV       = 4'd3;
  localparam logic [3:0] KIND_PUSH_FRONT = 4'd4;
  localparam logic [3:0] KIND_PUSH_BACK  = 4'd5;
  localparam logic [3:0] KIND_PUSH_AFTER = 4'd6;
  localparam logic [3:0] KIND_POP_FRONT  = 4'd7;
  localparam logic [3:0] KIND_POP_BACK   = 4'd8;
  localparam logic [3:0] KIND_POP_CURSOR = 4'd9;
  localparam logic [3:0] KIND_CLEAR      = 4'd10;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_NONE = 2'd1;
  localparam logic [1:0] STATUS_FULL = 2'd2;

  typedef struct packed {
    logic [3:0]  kind;
    logic [31:0] data_in;
  } cmd_t;

  typedef struct packed {
    logic [31:0] data_out;
    logic        has_data;
    logic [1:0]  status;
  } rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MOVE_LINK,
    ST_MOVE_DATA,
    ST_ALLOC,
    ST_PUSH_LINK,
    ST_PUSH_W1,
    ST_PUSH_W2,
    ST_PUSH_W3,
    ST_POP_RD,
    ST_POP_W1,
    ST_POP_W2
  } ctrl_state_e;

endpackage

FILE: src/doubly_linked_list_cursor_engine_top.sv
// Top level of the doubly linked list cursor engine: sequencer, node data
// RAM, node link RAM and the response register.
// Depends on dllce_pkg, dllce_ram and dllce_ctrl.
//
//   Channel    Ports                    Handshake
//   ---------  -----------------------  -----------------------------------
//   command    start, busy, cmd_i       taken when start is high, busy low
//   response   done_o, rsp_o            shown for one cycle while done_o high
//
// A command's response appears on the cycle after it completes. A move
// reads the link RAM (next and prev only), then the data RAM. A successful
// push makes an optional free list read and an optional read of the
// anchor's links, then writes the new node and up to two neighbor links.
// A pop reads the node, then makes up to three link writes. Refused pushes,
// clears and commands that find nothing before any read finish when accepted;
// the single link RAM write port puts each link write in its own state. Reset
// clears the list registers and the response strobe, not the pool RAMs.
// The receiver cannot stall: every response is taken in the cycle it is shown.
module doubly_linked_list_cursor_engine_top #(
  parameter int CAPACITY   = 256,
  parameter int DATA_WIDTH = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  dllce_pkg::cmd_t cmd_i,
  output logic            done_o,
  output dllce_pkg::rsp_t rsp_o
);

  // Index width includes the null code, which equals CAPACITY.
  localparam int IW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);

  logic [AW-1:0]         raddr, waddr;
  logic                  d_re, d_we, l_re, l_we;
  logic [DATA_WIDTH-1:0] d_wdata, d_rdata;
  logic [2*IW-1:0]       l_wmask, l_wdata, l_rdata;
  logic                  done;
  dllce_pkg::rsp_t       rsp;
  logic                  done_q;
  dllce_pkg::rsp_t       rsp_q;

  dllce_ctrl #(
    .CAPACITY  (CAPACITY),
    .DATA_WIDTH(DATA_WIDTH)
  ) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .busy_o   (busy),
    .cmd_i    (cmd_i),
    .done_o   (done),
    .rsp_o    (rsp),
    .raddr_o  (raddr),
    .waddr_o  (waddr),
    .d_re_o   (d_re),
    .d_we_o   (d_we),
    .d_wdata_o(d_wdata),
    .d_rdata_i(d_rdata),
    .l_re_o   (l_re),
    .l_we_o   (l_we),
    .l_wmask_o(l_wmask),
    .l_wdata_o(l_wdata),
    .l_rdata_i(l_rdata)
  );

  // Node data words, written once per successful push.
  dllce_ram #(
    .DEPTH(CAPACITY),
    .WIDTH(DATA_WIDTH)
  ) u_data_ram (
    .clk_i  (clk_i),
    .we_i   (d_we),
    .wmask_i({DATA_WIDTH{1'b1}}),
    .waddr_i(waddr),
    .wdata_i(d_wdata),
    .re_i   (d_re),
    .raddr_i(raddr),
    .rdata_o(d_rdata)
  );

  // Node links, next in the upper half and prev in the lower half. The bit
  // mask lets a neighbor's single link be rewritten without a read.
  dllce_ram #(
    .DEPTH(CAPACITY),
    .WIDTH(2 * IW)
  ) u_link_ram (
    .clk_i  (clk_i),
    .we_i   (l_we),
    .wmask_i(l_wmask),
    .waddr_i(waddr),
    .wdata_i(l_wdata),
    .re_i   (l_re),
    .raddr_i(raddr),
    .rdata_o(l_rdata)
  );

  // Response register; the strobe is cleared by reset, the payload is not.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= done;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      rsp_q <= rsp;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

FILE: src/dllce_ram.sv
// Simple dual port synchronous RAM with one write port, one read port and a
// bit write mask. Read data is registered.
// No package dependencies.
module dllce_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [WIDTH-1:0]         wmask_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      for (int b = 0; b < WIDTH; b++) begin
        if (wmask_i[b]) begin
          mem_q[waddr_i][b] <= wdata_i[b];
        end
      end
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/dllce_ctrl.sv
// Command sequencer of the linked list engine: list registers, node
// allocation and the read-modify-write steps on the data and link RAMs.
// Depends on dllce_pkg.
module dllce_ctrl #(
  parameter int CAPACITY   = 256,
  parameter int DATA_WIDTH = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  dllce_pkg::cmd_t                   cmd_i,
  output logic                              done_o,
  output dllce_pkg::rsp_t                   rsp_o,
  output logic [$clog2(CAPACITY)-1:0]       raddr_o,
  output logic [$clog2(CAPACITY)-1:0]       waddr_o,
  output logic                              d_re_o,
  output logic                              d_we_o,
  output logic [DATA_WIDTH-1:0]             d_wdata_o,
  input  logic [DATA_WIDTH-1:0]             d_rdata_i,
  output logic                              l_re_o,
  output logic                              l_we_o,
  output logic [2*$clog2(CAPACITY+1)-1:0]   l_wmask_o,
  output logic [2*$clog2(CAPACITY+1)-1:0]   l_wdata_o,
  input  logic [2*$clog2(CAPACITY+1)-1:0]   l_rdata_i
);

  localparam int IW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);
  localparam logic [IW-1:0]   NIL       = IW'(CAPACITY);
  localparam logic [2*IW-1:0] MASK_NEXT = {{IW{1'b1}}, {IW{1'b0}}};
  localparam logic [2*IW-1:0] MASK_PREV = {{IW{1'b0}}, {IW{1'b1}}};
  localparam logic [2*IW-1:0] MASK_ALL  = {(2*IW){1'b1}};

  function automatic logic live(input logic [IW-1:0] x);
    return x < NIL;
  endfunction

  function automatic logic [IW-1:0] norm(input logic [IW-1:0] x);
    return live(x) ? x : NIL;
  endfunction

  dllce_pkg::ctrl_state_e state_q, state_d;
  logic [IW-1:0]         head_q, head_d, tail_q, tail_d, cur_q, cur_d;
  logic [IW-1:0]         free_q, free_d, fresh_q, fresh_d;
  logic [IW-1:0]         n_q, n_d, p_q, p_d, q_q, q_d;
  logic [3:0]            kind_q, kind_d;
  logic [DATA_WIDTH-1:0] din_q, din_d, dat_q, dat_d;

  logic [IW-1:0] rd_next, rd_prev, move_tgt, pop_tgt, anchor, link_sel;
  logic          use_anchor, refuse;
  logic [IW-1:0] raddr_idx, waddr_idx;

  assign rd_next = l_rdata_i[2*IW-1:IW];
  assign rd_prev = l_rdata_i[IW-1:0];

  assign move_tgt = (cmd_i.kind == dllce_pkg::KIND_FIRST) ? head_q : tail_q;
  assign pop_tgt  = (cmd_i.kind == dllce_pkg::KIND_POP_FRONT) ? head_q :
                    (cmd_i.kind == dllce_pkg::KIND_POP_BACK)  ? tail_q : cur_q;
  assign anchor   = (cmd_i.kind == dllce_pkg::KIND_PUSH_BACK) ? tail_q : cur_q;
  assign use_anchor = (cmd_i.kind != dllce_pkg::KIND_PUSH_FRONT) && live(anchor);
  // Inserting behind a null cursor is only allowed on an empty list.
  assign refuse     = (cmd_i.kind != dllce_pkg::KIND_PUSH_FRONT) && !live(anchor)
                      && live(head_q);
  assign link_sel   = (kind_q == dllce_pkg::KIND_NEXT) ? rd_next : rd_prev;

  assign raddr_o = raddr_idx[AW-1:0];
  assign waddr_o = waddr_idx[AW-1:0];
  assign busy_o  = (state_q != dllce_pkg::ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dllce_pkg::ST_IDLE;
      head_q  <= NIL;
      tail_q  <= NIL;
      cur_q   <= NIL;
      free_q  <= NIL;
      fresh_q <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      cur_q   <= cur_d;
      free_q  <= free_d;
      fresh_q <= fresh_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q    <= n_d;
    p_q    <= p_d;
    q_q    <= q_d;
    kind_q <= kind_d;
    din_q  <= din_d;
    dat_q  <= dat_d;
  end

  always_comb begin
    state_d = state_q;
    head_d  = head_q;
    tail_d  = tail_q;
    cur_d   = cur_q;
    free_d  = free_q;
    fresh_d = fresh_q;
    n_d     = n_q;
    p_d     = p_q;
    q_d     = q_q;
    kind_d  = kind_q;
    din_d   = din_q;
    dat_d   = dat_q;

    raddr_idx = '0;
    waddr_idx = '0;
    d_re_o    = 1'b0;
    d_we_o    = 1'b0;
    d_wdata_o = din_q;
    l_re_o    = 1'b0;
    l_we_o    = 1'b0;
    l_wmask_o = MASK_ALL;
    l_wdata_o = {q_q, p_q};
    done_o    = 1'b0;
    rsp_o     = '0;

    unique case (state_q)
      dllce_pkg::ST_IDLE: begin
        if (start_i) begin
          kind_d = cmd_i.kind;
          din_d  = DATA_WIDTH'(cmd_i.data_in);
          unique case (cmd_i.kind)
            dllce_pkg::KIND_FIRST, dllce_pkg::KIND_LAST: begin
              if (live(move_tgt)) begin
                cur_d     = move_tgt;
                raddr_idx = move_tgt;
                d_re_o    = 1'b1;
                state_d   = dllce_pkg::ST_MOVE_DATA;
              end else begin
                done_o       = 1'b1;
                rsp_o.status = dllce_pkg::STATUS_NONE;
              end
            end
            dllce_pkg::KIND_NEXT, dllce_pkg::KIND_PREV: begin
              if (live(cur_q)) begin
                raddr_idx = cur_q;
                l_re_o    = 1'b1;
                state_d   = dllce_pkg::ST_MOVE_LINK;
              end else begin
                done_o       = 1'b1;
                rsp_o.status = dllce_pkg::STATUS_NONE;
              end
            end
            dllce_pkg::KIND_PUSH_FRONT, dllce_pkg::KIND_PUSH_BACK,
            dllce_pkg::KIND_PUSH_AFTER: begin
              p_d = use_anchor ? anchor : NIL;
              q_d = head_q;
              if (refuse) begin
                done_o       = 1'b1;
                rsp_o.status = dllce_pkg::STATUS_NONE;
              end else if (live(free_q)) begin
                n_d       = free_q;
                raddr_idx = free_q;
                l_re_o    = 1'b1;
                state_d   = dllce_pkg::ST_ALLOC;
              end else if (fresh_q < NIL) begin
                n_d     = fresh_q;
                fresh_d = fresh_q + IW'(1);
                if (use_anchor) begin
                  raddr_idx = anchor;
                  l_re_o    = 1'b1;
                  state_d   = dllce_pkg::ST_PUSH_LINK;
                end else begin
                  state_d = dllce_pkg::ST_PUSH_W1;
                end
              end else begin
                done_o       = 1'b1;
                rsp_o.status = dllce_pkg::STATUS_FULL;
              end
            end
            dllce_pkg::KIND_POP_FRONT, dllce_pkg::KIND_POP_BACK,
            dllce_pkg::KIND_POP_CURSOR: begin
              if (live(pop_tgt)) begin
                n_d       = pop_tgt;
                raddr_idx = pop_tgt;
                l_re_o    = 1'b1;
                d_re_o    = 1'b1;
                state_d   = dllce_pkg::ST_POP_RD;
              end else begin
                cur_d        = NIL;
                done_o       = 1'b1;
                rsp_o.status = dllce_pkg::STATUS_NONE;
              end
            end
            dllce_pkg::KIND_CLEAR: begin
              head_d  = NIL;
              tail_d  = NIL;
              cur_d   = NIL;
              free_d  = NIL;
              fresh_d = '0;
              done_o  = 1'b1;
            end
            default: begin
              done_o = 1'b1;
            end
          endcase
        end
      end

      dllce_pkg::ST_MOVE_LINK: begin
        cur_d = norm(link_sel);
        if (live(link_sel)) begin
          raddr_idx = link_sel;
          d_re_o    = 1'b1;
          state_d   = dllce_pkg::ST_MOVE_DATA;
        end else begin
          done_o       = 1'b1;
          rsp_o.status = dllce_pkg::STATUS_NONE;
          state_d      = dllce_pkg::ST_IDLE;
        end
      end

      dllce_pkg::ST_MOVE_DATA: begin
        done_o         = 1'b1;
        rsp_o.data_out = 32'(d_rdata_i);
        rsp_o.has_data = 1'b1;
        state_d        = dllce_pkg::ST_IDLE;
      end

      dllce_pkg::ST_ALLOC: begin
        free_d = norm(rd_next);
        if (live(p_q)) begin
          raddr_idx = p_q;
          l_re_o    = 1'b1;
          state_d   = dllce_pkg::ST_PUSH_LINK;
        end else begin
          state_d = dllce_pkg::ST_PUSH_W1;
        end
      end

      dllce_pkg::ST_PUSH_LINK: begin
        q_d     = norm(rd_next);
        state_d = dllce_pkg::ST_PUSH_W1;
      end

      dllce_pkg::ST_PUSH_W1: begin
        waddr_idx = n_q;
        d_we_o    = 1'b1;
        l_we_o    = 1'b1;
        state_d   = dllce_pkg::ST_PUSH_W2;
      end

      dllce_pkg::ST_PUSH_W2: begin
        if (live(q_q)) begin
          waddr_idx = q_q;
          l_we_o    = 1'b1;
          l_wmask_o = MASK_PREV;
          l_wdata_o = {n_q, n_q};
        end else begin
          tail_d = n_q;
        end
        state_d = dllce_pkg::ST_PUSH_W3;
      end

      dllce_pkg::ST_PUSH_W3: begin
        if (live(p_q)) begin
          waddr_idx = p_q;
          l_we_o    = 1'b1;
          l_wmask_o = MASK_NEXT;
          l_wdata_o = {n_q, n_q};
        end else begin
          head_d = n_q;
        end
        cur_d   = n_q;
        done_o  = 1'b1;
        state_d = dllce_pkg::ST_IDLE;
      end

      dllce_pkg::ST_POP_RD: begin
        dat_d = d_rdata_i;
        p_d   = norm(rd_prev);
        q_d   = norm(rd_next);
        if (live(rd_prev)) begin
          waddr_idx = rd_prev;
          l_we_o    = 1'b1;
          l_wmask_o = MASK_NEXT;
          l_wdata_o = {norm(rd_next), norm(rd_next)};
        end else begin
          head_d = norm(rd_next);
        end
        state_d = dllce_pkg::ST_POP_W1;
      end

      dllce_pkg::ST_POP_W1: begin
        if (live(q_q)) begin
          waddr_idx = q_q;
          l_we_o    = 1'b1;
          l_wmask_o = MASK_PREV;
          l_wdata_o = {p_q, p_q};
        end else begin
          tail_d = p_q;
        end
        state_d = dllce_pkg::ST_POP_W2;
      end

      dllce_pkg::ST_POP_W2: begin
        // The popped node goes to the front of the free list.
        waddr_idx      = n_q;
        l_we_o         = 1'b1;
        l_wmask_o      = MASK_NEXT;
        l_wdata_o      = {free_q, free_q};
        free_d         = n_q;
        cur_d          = q_q;
        done_o         = 1'b1;
        rsp_o.data_out = 32'(dat_q);
        rsp_o.has_data = 1'b1;
        state_d        = dllce_pkg::ST_IDLE;
      end

      default: begin
        state_d = dllce_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: src/dllce_chk.sv
// Port level checker for the linked list engine, bound to the top level.
// Depends on dllce_pkg and doubly_linked_list_cursor_engine_top.
module dllce_chk (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            start,
  input logic            busy,
  input logic            done_o,
  input dllce_pkg::rsp_t rsp_o
);

  // A response without list data carries a zero data word.
  a_zero_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !rsp_o.has_data) |-> (rsp_o.data_out == 32'd0))
    else $error("response without data has nonzero data word");

  // Data is only returned by a successful move or pop.
  a_data_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.has_data) |-> (rsp_o.status == dllce_pkg::STATUS_OK))
    else $error("response with data has a failure status");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (rsp_o.status == dllce_pkg::STATUS_OK ||
                rsp_o.status == dllce_pkg::STATUS_NONE ||
                rsp_o.status == dllce_pkg::STATUS_FULL))
    else $error("response carries an undefined status code");

  // An accepted transaction either keeps the engine busy or answers at once.
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || done_o))
    else $error("accepted transaction neither busy nor answered");

endmodule

bind doubly_linked_list_cursor_engine_top dllce_chk u_chk (
  .clk_i (clk_i),
  .rst_ni(rst_ni),
  .start (start),
  .busy  (busy),
  .done_o(done_o),
  .rsp_o (rsp_o)
);

FILE: bench/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for doubly_linked_list_cursor_engine_top: drives command
// transactions and checks every response against a shadow copy of the list.
// Depends on dllce_pkg and the engine's RTL.
module tb;

  localparam int unsigned POOL_SIZE = 256;
  // Index one past the pool marks a null link, exactly as in the engine.
  localparam logic [8:0] NULL_LINK = 9'd256;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned RANDOM_ITEMS = 100;
  localparam int unsigned CHUNK_ITEMS = 25;
  localparam int unsigned SETTLE_CYCLES = 12;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic start;
  logic busy;
  dllce_pkg::cmd_t cmd_i;
  logic done_o;
  dllce_pkg::rsp_t rsp_o;

  doubly_linked_list_cursor_engine_top #(
    .CAPACITY  (POOL_SIZE),
    .DATA_WIDTH(32)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .cmd_i (cmd_i),
    .done_o(done_o),
    .rsp_o (rsp_o)
  );

  // 4 ns period: one pass through the always block makes one clock period.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow list. This is an independent copy of the node pool, the list
  // registers and the free list. It is updated once per accepted command
  // transaction, at the very edge where the engine accepts it.
  // ---------------------------------------------------------------------------
  logic [31:0] node_word [POOL_SIZE];
  logic [8:0]  link_fwd  [POOL_SIZE];
  logic [8:0]  link_back [POOL_SIZE];
  logic [8:0]  head_q;
  logic [8:0]  tail_q;
  logic [8:0]  cursor_q;
  logic [8:0]  free_q;
  int unsigned fresh_q;

  // Responses predicted for accepted commands, oldest first.
  dllce_pkg::rsp_t pending_rsp [$];
  dllce_pkg::rsp_t want_rsp;
  int unsigned     fail_count = 0;
  // When clear, the sender issues back to back with no idle cycles.
  bit              pace_on = 1'b1;

  function automatic bit is_live(input logic [8:0] idx);
    return idx < NULL_LINK;
  endfunction

  function automatic dllce_pkg::rsp_t make_rsp(input logic [31:0] word, input logic has,
                                               input logic [1:0] code);
    dllce_pkg::rsp_t r;
    r.data_out = word;
    r.has_data = has;
    r.status   = code;
    return r;
  endfunction

  function automatic void empty_pool();
    head_q   = NULL_LINK;
    tail_q   = NULL_LINK;
    cursor_q = NULL_LINK;
    free_q   = NULL_LINK;
    fresh_q  = 0;
  endfunction

  // Recycled nodes are preferred; otherwise the next never-used index is taken.
  function automatic logic [8:0] take_node();
    logic [8:0] n;
    if (is_live(free_q)) begin
      n      = free_q;
      free_q = link_fwd[n];
      return n;
    end
    if (fresh_q < POOL_SIZE) begin
      n = fresh_q[8:0];
      fresh_q++;
      return n;
    end
    return NULL_LINK;
  endfunction

  function automatic dllce_pkg::rsp_t cursor_word();
    if (is_live(cursor_q)) return make_rsp(node_word[cursor_q], 1'b1, dllce_pkg::STATUS_OK);
    return make_rsp(32'd0, 1'b0, dllce_pkg::STATUS_NONE);
  endfunction

  // A null cursor on a non-empty list refuses the insert before the full check,
  // so the existing list is never cut loose.
  function automatic dllce_pkg::rsp_t insert_after(input logic [31:0] word);
    logic [8:0] n;
    logic [8:0] after;
    if (!is_live(cursor_q) && is_live(head_q)) begin
      return make_rsp(32'd0, 1'b0, dllce_pkg::STATUS_NONE);
    end
    n = take_node();
    if (!is_live(n)) return make_rsp(32'd0, 1'b0, dllce_pkg::STATUS_FULL);
    node_word[n] = word;
    if (!is_live(cursor_q)) begin
      link_fwd[n]  = NULL_LINK;
      link_back[n] = NULL_LINK;
      head_q       = n;
      tail_q       = n;
    end else begin
      after        = link_fwd[cursor_q];
      link_back[n] = cursor_q;
      link_fwd[n]  = after;
      if (is_live(after)) link_back[after] = n;
      else tail_q = n;
      link_fwd[cursor_q] = n;
    end
    cursor_q = n;
    return make_rsp(32'd0, 1'b0, dllce_pkg::STATUS_OK);
  endfunction

  // Unlinks the cursor node, moves the cursor to its successor and puts the
  // node at the top of the free list.
  function automatic dllce_pkg::rsp_t unlink_cursor();
    logic [8:0]  n;
    logic [8:0]  p;
    logic [8:0]  q;
    logic [31:0] word;
    n = cursor_q;
    if (!is_live(n)) begin
      cursor_q = NULL_LINK;
      return make_rsp(32'd0, 1'b0, dllce_pkg::STATUS_NONE);
    end
    word = node_word[n];
    p    = link_back[n];
    q    = link_fwd[n];
    if (is_live(p)) link_fwd[p] = q;
    else head_q = q;
    if (is_live(q)) link_back[q] = p;
    else tail_q = p;
    cursor_q    = q;
    link_fwd[n] = free_q;
    free_q      = n;
    return make_rsp(word, 1'b1, dllce_pkg::STATUS_OK);
  endfunction

  // Applies one command to the shadow list and returns the response it owes.
  function automatic dllce_pkg::rsp_t list_apply(input dllce_pkg::cmd_t c);
    dllce_pkg::rsp_t r;
    logic [8:0]      saved;
    case (c.kind)
      dllce_pkg::KIND_FIRST: begin
        if (is_live(head_q)) cursor_q = head_q;
        r = cursor_word();
      end
      dllce_pkg::KIND_NEXT: begin
        if (is_live(cursor_q)) cursor_q = link_fwd[cursor_q];
        r = cursor_word();
      end
      dllce_pkg::KIND_LAST: begin
        if (is_live(tail_q)) cursor_q = tail_q;
        r = cursor_word();
      end
      dllce_pkg::KIND_PREV: begin
        if (is_live(cursor_q)) cursor_q = link_back[cursor_q];
        r = cursor_word();
      end
      dllce_pkg::KIND_PUSH_FRONT: begin
        saved = take_node();
        if (!is_live(saved)) begin
          r = make_rsp(32'd0, 1'b0, dllce_pkg::STATUS_FULL);
        end else begin
          node_word[saved] = c.data_in;
          link_back[saved] = NULL_LINK;
          link_fwd[saved]  = head_q;
          if (is_live(head_q)) link_back[head_q] = saved;
          else tail_q = saved;
          head_q   = saved;
          cursor_q = saved;
          r = make_rsp(32'd0, 1'b0, dllce_pkg::STATUS_OK);
        end
      end
      dllce_pkg::KIND_PUSH_BACK: begin
        // A refused push at the back leaves the cursor where it was.
        saved    = cursor_q;
        cursor_q = tail_q;
        r        = insert_after(c.data_in);
        if (r.status != dllce_pkg::STATUS_OK) cursor_q = saved;
      end
      dllce_pkg::KIND_PUSH_AFTER: r = insert_after(c.data_in);
      dllce_pkg::KIND_POP_FRONT: begin
        cursor_q = head_q;
        r = unlink_cursor();
      end
      dllce_pkg::KIND_POP_BACK: begin
        cursor_q = tail_q;
        r = unlink_cursor();
      end
      dllce_pkg::KIND_POP_CURSOR: r = unlink_cursor();
      dllce_pkg::KIND_CLEAR: begin
        empty_pool();
        r = make_rsp(32'd0, 1'b0, dllce_pkg::STATUS_OK);
      end
      default: r = make_rsp(32'd0, 1'b0, dllce_pkg::STATUS_OK);
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Response checker. done_o and rsp_o are registered, so at the rising edge
  // they still show the response of the cycle that this edge ends. Every
  // strobe must match the oldest prediction field by field.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && done_o === 1'b1) begin
      if (pending_rsp.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("ERROR: unexpected response data_out=%h has_data=%b status=%0d",
                   rsp_o.data_out, rsp_o.has_data, rsp_o.status);
      end else begin
        want_rsp = pending_rsp.pop_front();
        if (rsp_o.data_out !== want_rsp.data_out || rsp_o.has_data !== want_rsp.has_data ||
            rsp_o.status !== want_rsp.status) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("ERROR: response mismatch: expected %h/%b/%0d, got %h/%b/%0d",
                     want_rsp.data_out, want_rsp.has_data, want_rsp.status,
                     rsp_o.data_out, rsp_o.has_data, rsp_o.status);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Command sender. Inputs change only at falling edges. Start is raised at
  // most once per falling edge: when the next transaction follows with no
  // gap, start simply stays high and only cmd_i changes. The transaction is
  // taken at the first rising edge that sees busy low, and the shadow list
  // is stepped at that same edge.
  // ---------------------------------------------------------------------------
  task automatic send_cmd(input logic [3:0] kind, input logic [31:0] word);
    int unsigned     gap;
    dllce_pkg::cmd_t c;
    gap       = pace_on ? $urandom_range(0, 6) : 0;
    c.kind    = kind;
    c.data_in = word;
    @(negedge clk_i);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start <= 1'b1;
    cmd_i <= c;
    do @(posedge clk_i); while (busy !== 1'b0);
    pending_rsp.push_back(list_apply(c));
  endtask

  // Holds start low until every outstanding response has been checked.
  task automatic wait_all_done();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
  endtask

  // Every move and pop on an empty list reports nothing there; unused kinds
  // answer ok and change nothing; an insert after a null cursor on an empty
  // list creates the only node.
  task automatic test_empty_list();
    send_cmd(dllce_pkg::KIND_FIRST, 32'd0);
    send_cmd(dllce_pkg::KIND_NEXT, 32'd0);
    send_cmd(dllce_pkg::KIND_LAST, 32'd0);
    send_cmd(dllce_pkg::KIND_PREV, 32'd0);
    send_cmd(dllce_pkg::KIND_POP_FRONT, 32'd0);
    send_cmd(dllce_pkg::KIND_POP_BACK, 32'd0);
    send_cmd(dllce_pkg::KIND_POP_CURSOR, 32'd0);
    send_cmd(4'd11, 32'hFFFF_FFFF);
    send_cmd(4'd15, 32'h5555_AAAA);
    send_cmd(dllce_pkg::KIND_PUSH_AFTER, 32'hA5A5_5A5A);
    send_cmd(dllce_pkg::KIND_POP_CURSOR, 32'd0);
    wait_all_done();
  endtask

  // Walks a three-node list in both directions, falls off both ends, and
  // checks that an insert after a null cursor on a live list is refused.
  task automatic test_link_walk();
    send_cmd(dllce_pkg::KIND_PUSH_FRONT, 32'h0000_0000);
    send_cmd(dllce_pkg::KIND_PUSH_BACK, 32'hFFFF_FFFF);
    send_cmd(dllce_pkg::KIND_FIRST, 32'd0);
    send_cmd(dllce_pkg::KIND_PUSH_AFTER, 32'h1234_5678);
    send_cmd(dllce_pkg::KIND_FIRST, 32'd0);
    send_cmd(dllce_pkg::KIND_NEXT, 32'd0);
    send_cmd(dllce_pkg::KIND_NEXT, 32'd0);
    send_cmd(dllce_pkg::KIND_NEXT, 32'd0);
    send_cmd(dllce_pkg::KIND_PUSH_AFTER, 32'hDEAD_BEEF);
    send_cmd(dllce_pkg::KIND_PREV, 32'd0);
    send_cmd(dllce_pkg::KIND_LAST, 32'd0);
    send_cmd(dllce_pkg::KIND_PREV, 32'd0);
    send_cmd(dllce_pkg::KIND_PREV, 32'd0);
    send_cmd(dllce_pkg::KIND_PREV, 32'd0);
    send_cmd(dllce_pkg::KIND_POP_CURSOR, 32'd0);
    send_cmd(dllce_pkg::KIND_FIRST, 32'd0);
    send_cmd(dllce_pkg::KIND_NEXT, 32'd0);
    send_cmd(dllce_pkg::KIND_POP_CURSOR, 32'd0);
    send_cmd(dllce_pkg::KIND_POP_FRONT, 32'd0);
    send_cmd(dllce_pkg::KIND_POP_BACK, 32'd0);
    send_cmd(dllce_pkg::KIND_POP_BACK, 32'd0);
    send_cmd(dllce_pkg::KIND_PUSH_FRONT, 32'h8000_0001);
    send_cmd(dllce_pkg::KIND_CLEAR, 32'd0);
    send_cmd(dllce_pkg::KIND_FIRST, 32'd0);
    wait_all_done();
  endtask

  // Fills the whole pool, then checks refusal by every push kind, the order
  // of the null-cursor and full checks, reuse of freed nodes, and that a push
  // succeeds after a clear.
  task automatic test_pool_full();
    send_cmd(dllce_pkg::KIND_CLEAR, 32'd0);
    for (int unsigned i = 0; i < POOL_SIZE; i++) begin
      send_cmd(dllce_pkg::KIND_PUSH_BACK, $urandom());
    end
    send_cmd(dllce_pkg::KIND_PUSH_FRONT, 32'h1111_1111);
    send_cmd(dllce_pkg::KIND_PUSH_BACK, 32'h2222_2222);
    send_cmd(dllce_pkg::KIND_PUSH_AFTER, 32'h3333_3333);
    send_cmd(dllce_pkg::KIND_LAST, 32'd0);
    send_cmd(dllce_pkg::KIND_NEXT, 32'd0);
    send_cmd(dllce_pkg::KIND_PUSH_AFTER, 32'h4444_4444);
    send_cmd(dllce_pkg::KIND_FIRST, 32'd0);
    send_cmd(dllce_pkg::KIND_POP_CURSOR, 32'd0);
    send_cmd(dllce_pkg::KIND_POP_FRONT, 32'd0);
    send_cmd(dllce_pkg::KIND_PUSH_FRONT, $urandom());
    send_cmd(dllce_pkg::KIND_PUSH_AFTER, $urandom());
    send_cmd(dllce_pkg::KIND_PUSH_BACK, $urandom());
    send_cmd(dllce_pkg::KIND_CLEAR, 32'd0);
    send_cmd(dllce_pkg::KIND_PUSH_FRONT, $urandom());
    send_cmd(dllce_pkg::KIND_LAST, 32'd0);
    wait_all_done();
  endtask

  // Weighted toward pushes so the list grows deep; pops and moves then
  // exercise long link chains, with an occasional clear or unused kind.
  function automatic logic [3:0] pick_kind();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 15) return dllce_pkg::KIND_PUSH_FRONT;
    if (roll < 30) return dllce_pkg::KIND_PUSH_BACK;
    if (roll < 42) return dllce_pkg::KIND_PUSH_AFTER;
    if (roll < 50) return dllce_pkg::KIND_FIRST;
    if (roll < 58) return dllce_pkg::KIND_NEXT;
    if (roll < 64) return dllce_pkg::KIND_LAST;
    if (roll < 70) return dllce_pkg::KIND_PREV;
    if (roll < 77) return dllce_pkg::KIND_POP_FRONT;
    if (roll < 83) return dllce_pkg::KIND_POP_BACK;
    if (roll < 91) return dllce_pkg::KIND_POP_CURSOR;
    if (roll < 97) return 4'($urandom_range(11, 15));
    return dllce_pkg::KIND_CLEAR;
  endfunction

  // Random traffic in chunks; about one chunk in four runs with no idle
  // cycles at all, and one chunk in the middle drains before going on.
  task automatic test_random_mix();
    for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % CHUNK_ITEMS == 0) pace_on = ($urandom_range(0, 3) != 0);
      if (i == RANDOM_ITEMS / 2) wait_all_done();
      send_cmd(pick_kind(), $urandom());
    end
    pace_on = 1'b1;
  endtask

  initial begin
    rst_ni = 1'b0;
    start  = 1'b0;
    cmd_i  = '0;
    empty_pool();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_empty_list();
    test_link_walk();
    test_pool_full();
    test_random_mix();

    // All commands are in; let the last responses arrive, then keep running
    // to catch any stray strobe.
    wait_all_done();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog: a correct run needs well under a tenth of this time.
  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

endmodule
